@@ src/kmed_pkg.sv @@
// kmed_pkg: shared types and constants for the key matrix debouncer
// used by kmed_lane, kmed_merge and key_matrix_eager_debouncer
`timescale 1ns / 1ps

package kmed_pkg;

    // configuration port geometry
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 8;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEBOUNCE_TICKS = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LONE_KEY_ONLY  = 8'd1;

    // register reset values
    localparam logic [7:0] DEBOUNCE_TICKS_RESET = 8'd5;
    localparam logic       LONE_KEY_ONLY_RESET  = 1'b0;

    // width of the key matrix fields on the stream ports
    localparam int MATRIX_BITS = 64;

    // what one row lane reports to the merge stage
    typedef struct packed {
        logic diff;   // row differs from debounced row
        logic bad;    // release or more than one press in this row
    } lane_stat_t;

endpackage

@@ src/kmed_lane.sv @@
// kmed_lane: compares one raw row against the debounced row
// depends on kmed_pkg for lane_stat_t
`timescale 1ns / 1ps

module kmed_lane #(
    parameter int COLS = 8
) (
    input  logic [COLS-1:0]        raw_row,
    input  logic [COLS-1:0]        deb_row,
    output logic [COLS-1:0]        press,
    output kmed_pkg::lane_stat_t   stat
);

    logic [COLS-1:0] diff;

    // new presses and overall difference
    assign diff  = raw_row ^ deb_row;
    assign press = raw_row & ~deb_row;

    // a row is bad if it has a release or more than one press
    assign stat.diff = |diff;
    assign stat.bad  = (diff != press) || ((press & (press - COLS'(1))) != '0);

endmodule

@@ src/kmed_merge.sv @@
// kmed_merge: combines the row lane results into the eager press decision
// depends on kmed_pkg for lane_stat_t
`timescale 1ns / 1ps

module kmed_merge #(
    parameter int ROWS = 8,
    parameter int COLS = 8
) (
    input  kmed_pkg::lane_stat_t [ROWS-1:0] lane_stat,
    input  logic [ROWS*COLS-1:0]            press_key,
    output logic                            eager_ok,
    output logic [COLS-1:0]                 press_row
);

    logic [ROWS-1:0] diff_rows;
    logic [ROWS-1:0] bad_rows;

    // gather per-row flags and the press of whichever row changed
    always_comb
    begin
        press_row = '0;
        for (int r = 0; r < ROWS; r++)
        begin
            diff_rows[r] = lane_stat[r].diff;
            bad_rows[r]  = lane_stat[r].bad;
            press_row    = press_row | press_key[r*COLS +: COLS];
        end
    end

    // exactly one row with a single press and no bad rows
    assign eager_ok = !(|bad_rows) && (|diff_rows)
                      && ((diff_rows & (diff_rows - ROWS'(1))) == '0);

endmodule

@@ src/key_matrix_eager_debouncer.sv @@
// key_matrix_eager_debouncer: top level, state, output register and config port
// depends on kmed_pkg, kmed_lane and kmed_merge
`timescale 1ns / 1ps

// Usage
//   s_tdata carries one key matrix scan per word: raw_matrix in bits 63:0 and
//   time_now above it; s_tuser carries scan_changed. m_tdata returns the
//   debounced matrix and m_tuser flags that it changed in this step. Every
//   accepted scan gives exactly one result word.
//   cfg_valid/cfg_index/cfg_data write debounce_ticks (index 0) and
//   lone_key_only (index 1); cfg_ready is always high, other indexes are
//   dropped. Write only while no result is outstanding.
//   m_tvalid rises in the cycle after acceptance. Throughput is one scan per
//   cycle unless the receiver stalls: the row compare runs as one lane per
//   row plus a merge; state update and output register close in the same cycle.
//   A single output register sits between the sides; while the receiver
//   stalls with a word held, s_tready drops, and it rises again in the cycle
//   the held word is taken, so a new scan can enter alongside.
//   Reset clears the debounced matrix, the wait and the output valid, and
//   loads the register defaults (5 ticks, lone-key mode off).
module key_matrix_eager_debouncer #(
    parameter int ROWS      = 8,
    parameter int COLS      = 8,
    parameter int TIME_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // input scans
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // s_tdata: raw_matrix, time_now, zero fill
    input  logic [((64+TIME_BITS+7)/8)*8-1:0]     s_tdata,
    // s_tuser: scan_changed
    input  logic                                  s_tuser,
    // results
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // m_tdata: debounced_matrix
    output logic [kmed_pkg::MATRIX_BITS-1:0]      m_tdata,
    // m_tuser: debounced_changed
    output logic                                  m_tuser,
    // configuration writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [kmed_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [kmed_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    localparam int MB        = kmed_pkg::MATRIX_BITS;
    localparam int KEY_BITS  = ROWS * COLS;
    localparam int AREA_BITS = (KEY_BITS < MB) ? KEY_BITS : MB;
    localparam logic [MB-1:0] AREA = {MB{1'b1}} >> (MB - AREA_BITS);

    logic [7:0]           debounce_ticks_reg;
    logic                 lone_key_only_reg;
    logic [MB-1:0]        deb_reg;
    logic [MB-1:0]        deb_next;
    logic                 pending_reg;
    logic                 pending_next;
    logic [TIME_BITS-1:0] start_reg;
    logic [TIME_BITS-1:0] start_next;
    logic                 out_valid_reg;
    logic [MB-1:0]        out_data_reg;
    logic                 out_changed_reg;

    logic                 in_accept;
    logic [MB-1:0]        raw;
    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] elapsed;
    logic [KEY_BITS-1:0]  raw_key;
    logic [KEY_BITS-1:0]  deb_key;
    logic [KEY_BITS-1:0]  press_key;
    logic [COLS-1:0]      press_row;
    logic [KEY_BITS-1:0]  press_bits;
    logic                 eager_ok;
    logic                 blocked;

    kmed_pkg::lane_stat_t [ROWS-1:0] lane_stat;

    // handshake
    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = !out_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    // unpack and mask to the key area
    assign raw     = s_tdata[MB-1:0] & AREA;
    assign now     = s_tdata[MB +: TIME_BITS];
    assign raw_key = KEY_BITS'(raw);
    assign deb_key = KEY_BITS'(deb_reg);

    // one compare lane per row
    for (genvar r = 0; r < ROWS; r++)
    begin : g_lane
        kmed_lane #(
            .COLS (COLS)
        ) u_lane (
            .raw_row (raw_key[r*COLS +: COLS]),
            .deb_row (deb_key[r*COLS +: COLS]),
            .press   (press_key[r*COLS +: COLS]),
            .stat    (lane_stat[r])
        );
    end

    // merge lane results
    kmed_merge #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_merge (
        .lane_stat (lane_stat),
        .press_key (press_key),
        .eager_ok  (eager_ok),
        .press_row (press_row)
    );

    // the press lives only in the row whose lane reported a difference
    always_comb
    begin
        press_bits = '0;
        for (int r = 0; r < ROWS; r++)
        begin
            if (lane_stat[r].diff)
            begin
                press_bits[r*COLS +: COLS] = press_row;
            end
        end
    end

    assign blocked = lone_key_only_reg && (deb_reg != '0);
    assign elapsed = now - start_reg;

    // debouncer state update
    always_comb
    begin
        deb_next     = deb_reg;
        pending_next = pending_reg;
        start_next   = start_reg;
        priority if (s_tuser)
        begin
            if (!pending_reg && !blocked && eager_ok)
            begin
                deb_next = deb_reg | (MB'(press_bits) & AREA);
            end
            pending_next = 1'b1;
            start_next   = now;
        end
        else if (pending_reg && (elapsed >= TIME_BITS'(debounce_ticks_reg)))
        begin
            deb_next     = raw;
            pending_next = 1'b0;
        end
        else
        begin
            // quiet scan with no elapsed wait: state holds
            deb_next = deb_reg;
        end
    end

    // state and config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deb_reg            <= '0;
            pending_reg        <= 1'b0;
            start_reg          <= '0;
            out_valid_reg      <= 1'b0;
            debounce_ticks_reg <= kmed_pkg::DEBOUNCE_TICKS_RESET;
            lone_key_only_reg  <= kmed_pkg::LONE_KEY_ONLY_RESET;
        end
        else
        begin
            if (in_accept)
            begin
                deb_reg     <= deb_next;
                pending_reg <= pending_next;
                start_reg   <= start_next;
            end
            if (in_accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == kmed_pkg::REG_DEBOUNCE_TICKS)
                begin
                    debounce_ticks_reg <= cfg_data[7:0];
                end
                else if (cfg_index == kmed_pkg::REG_LONE_KEY_ONLY)
                begin
                    lone_key_only_reg <= cfg_data[0];
                end
            end
        end
    end

    // output word register
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_data_reg    <= deb_next;
            out_changed_reg <= (deb_next != deb_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_changed_reg;

`ifndef SYNTH
    // a flagged scan always leaves a wait pending
    a_flag_sets_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && s_tuser) |=> pending_reg)
        else $error("flagged scan did not start the wait");

    // debounced bits outside the key area stay clear
    a_area_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (deb_reg & ~AREA) == '0)
        else $error("debounced bit outside key area");

    // a flagged scan during a wait leaves the debounced matrix unchanged
    a_no_eager_when_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && s_tuser && pending_reg) |=> !out_changed_reg)
        else $error("debounced matrix changed during a pending wait");

    // the held word always matches the current debounced state
    a_out_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg == deb_reg))
        else $error("output word out of step with debounced state");
`endif

endmodule

@@ tb/kmed_checker.sv @@
// kmed_checker: watches the scan, result and config channels of the key matrix
// debouncer, predicts every result word and compares it; depends on kmed_pkg
`timescale 1ns / 1ps

module kmed_checker #(
    parameter int SCAN_BITS = 80
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [SCAN_BITS-1:0]               s_tdata,
    input  logic                               s_tuser,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [kmed_pkg::MATRIX_BITS-1:0]   m_tdata,
    input  logic                               m_tuser,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [kmed_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [kmed_pkg::CFG_DATA_BITS-1:0] cfg_data,
    output int                                 fail_count,
    output int                                 words_left,
    output int                                 eager_count,
    output int                                 settle_count
);

    localparam int KEY_ROWS = 8;
    localparam int KEY_COLS = 8;

    typedef struct packed {
        logic [63:0] matrix;
        logic        changed;
    } key_word_t;

    // predicted debouncer state and registers
    logic [63:0] keys_q;
    logic        wait_q;
    logic [15:0] start_q;
    logic [7:0]  ticks_q;
    logic        lone_q;

    key_word_t   expected_words[$];

    // one scan through the debouncer: eager press, wait restart, settle
    function automatic key_word_t debounce_scan(input logic [63:0] raw, input logic flagged,
                                                input logic [15:0] now);
        logic [63:0] prior;
        logic [63:0] press_bits;
        logic [7:0]  raw_row;
        logic [7:0]  cur_row;
        logic [7:0]  diff;
        logic [7:0]  presses;
        logic        blocked;
        int          singles;
        key_word_t   w;
        prior = keys_q;
        if (flagged)
        begin
            if (!wait_q)
            begin
                blocked    = lone_q && (keys_q != '0);
                singles    = 0;
                press_bits = '0;
                // a lone new press in exactly one row may go through at once
                for (int r = 0; r < KEY_ROWS; r++)
                begin
                    raw_row = raw[r*KEY_COLS +: KEY_COLS];
                    cur_row = keys_q[r*KEY_COLS +: KEY_COLS];
                    diff    = raw_row ^ cur_row;
                    presses = raw_row & ~cur_row;
                    if (!blocked && diff != '0)
                    begin
                        if (diff != presses || (presses & (presses - 8'd1)) != '0)
                        begin
                            blocked = 1'b1;
                        end
                        else
                        begin
                            singles++;
                            press_bits = 64'(presses) << (r * KEY_COLS);
                        end
                    end
                end
                if (!blocked && singles == 1)
                begin
                    keys_q = keys_q | press_bits;
                    eager_count++;
                end
            end
            wait_q  = 1'b1;
            start_q = now;
        end
        else if (wait_q && 16'(now - start_q) >= {8'd0, ticks_q})
        begin
            // quiet long enough: follow the raw matrix
            if (raw != prior)
                settle_count++;
            keys_q = raw;
            wait_q = 1'b0;
        end
        w.matrix  = keys_q;
        w.changed = (keys_q != prior);
        return w;
    endfunction

    // compare results first, then queue the new scan, then track config writes
    always @(posedge clk or negedge rst_n)
    begin : watch
        key_word_t want;
        if (!rst_n)
        begin
            keys_q       = '0;
            wait_q       = 1'b0;
            start_q      = '0;
            ticks_q      = kmed_pkg::DEBOUNCE_TICKS_RESET;
            lone_q       = kmed_pkg::LONE_KEY_ONLY_RESET;
            fail_count   = 0;
            words_left   = 0;
            eager_count  = 0;
            settle_count = 0;
            expected_words.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: result word with nothing expected: matrix %h changed %b",
                             $time, m_tdata, m_tuser);
                    fail_count++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (m_tdata !== want.matrix)
                    begin
                        $display("%0t: debounced matrix expected %h actual %h",
                                 $time, want.matrix, m_tdata);
                        fail_count++;
                    end
                    if (m_tuser !== want.changed)
                    begin
                        $display("%0t: changed flag expected %b actual %b",
                                 $time, want.changed, m_tuser);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_words.push_back(debounce_scan(s_tdata[63:0], s_tuser,
                                                       s_tdata[79:64]));
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    kmed_pkg::REG_DEBOUNCE_TICKS: ticks_q = cfg_data;
                    kmed_pkg::REG_LONE_KEY_ONLY:  lone_q  = cfg_data[0];
                    default: ;
                endcase
            end
            words_left = expected_words.size();
        end
    end

endmodule

@@ tb/tb.sv @@
// tb: stimulus and verdict for key_matrix_eager_debouncer
// depends on kmed_pkg, the debouncer RTL and kmed_checker
`timescale 1ns / 1ps

module tb;

    localparam int SCAN_BITS    = ((64 + 16 + 7) / 8) * 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_SCANS = 1720;
    localparam int PHASES       = 10;

    logic                                clk       = 1'b0;
    logic                                rst_n     = 1'b0;
    logic                                s_tvalid  = 1'b0;
    logic                                s_tready;
    logic [SCAN_BITS-1:0]                s_tdata   = '0;
    logic                                s_tuser   = 1'b0;
    logic                                m_tvalid;
    logic                                m_tready  = 1'b0;
    logic [kmed_pkg::MATRIX_BITS-1:0]    m_tdata;
    logic                                m_tuser;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [kmed_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [kmed_pkg::CFG_DATA_BITS-1:0]  cfg_data  = '0;

    int fail_count;
    int words_left;
    int eager_count;
    int settle_count;

    int scans_sent   = 0;
    int results_seen = 0;
    int cycle_count  = 0;
    int stall_left   = 0;
    int settings_run = 1;

    logic        tx_idle_on = 1'b0;
    logic        rx_idle_on = 1'b0;
    logic [63:0] held       = '0;
    logic [63:0] last_raw   = '0;
    logic [15:0] stim_time  = '0;
    logic [7:0]  cur_ticks  = kmed_pkg::DEBOUNCE_TICKS_RESET;

    always #5 clk = ~clk;

    key_matrix_eager_debouncer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    kmed_checker #(
        .SCAN_BITS (SCAN_BITS)
    ) checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .words_left   (words_left),
        .eager_count  (eager_count),
        .settle_count (settle_count)
    );

    // receiver: random stall after each word when idling is on
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (m_tvalid && m_tready)
        begin
            stall_left = rx_idle_on ? $urandom_range(0, 5) : 0;
            m_tready <= (stall_left == 0);
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= (stall_left == 0);
        end
        else
            m_tready <= 1'b1;
    end

    // result count and run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (m_tvalid && m_tready)
            results_seen <= results_seen + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: run limit reached", $time);
            $display("== FAIL ==");
            $finish;
        end
    end

    // one scan word, after a random gap when idling is on
    task automatic send_scan(input logic [63:0] raw, input logic flagged,
                             input logic [15:0] stamp);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {stamp, raw};
        s_tuser  <= flagged;
        do @(posedge clk); while (!s_tready);
        scans_sent++;
    endtask

    // advance the timestamp and send a scan with an explicit change flag
    task automatic scan(input logic [63:0] raw, input logic flagged, input int dt);
        stim_time = stim_time + 16'(dt);
        send_scan(raw, flagged, stim_time);
        last_raw = raw;
    endtask

    // scan with the change flag taken from the previous raw scan
    task automatic step(input logic [63:0] raw, input int dt);
        scan(raw, raw != last_raw, dt);
    endtask

    // stop sending until every result word is back
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (results_seen != scans_sent);
    endtask

    // register writes, with one write to an unused index mixed in
    task automatic load_settings(input logic [7:0] ticks, input logic lone);
        logic [kmed_pkg::CFG_INDEX_BITS-1:0] idx [3];
        logic [kmed_pkg::CFG_DATA_BITS-1:0]  val [3];
        idx[0] = kmed_pkg::REG_DEBOUNCE_TICKS;
        val[0] = ticks;
        idx[1] = kmed_pkg::REG_LONE_KEY_ONLY;
        val[1] = {7'($urandom), lone};
        idx[2] = kmed_pkg::CFG_INDEX_BITS'(
                     $urandom_range(32'(kmed_pkg::REG_LONE_KEY_ONLY) + 1, 255));
        val[2] = kmed_pkg::CFG_DATA_BITS'($urandom);
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        cur_ticks = ticks;
        settings_run++;
    endtask

    // one stretch of key activity: a keystroke with bounce and quiet time,
    // or an unrelated noise scan
    task automatic random_activity();
        int          pick;
        int          n;
        logic [63:0] next_held;
        logic [63:0] raw;
        pick      = $urandom_range(0, 99);
        next_held = held;
        if (pick < 15)
        begin
            scan({$urandom, $urandom}, 1'($urandom), $urandom_range(0, 65535));
            held = last_raw;
        end
        else
        begin
            if (pick < 25)
                next_held = '0;
            else if (pick < 35)
                next_held = held | (64'd1 << $urandom_range(0, 63))
                                 | (64'd1 << $urandom_range(0, 63));
            else if ($countones(held) > 6)
                next_held = held & (held - 64'd1);
            else
                next_held = held ^ (64'd1 << $urandom_range(0, 63));
            // contact bounce between the old and new state
            n = $urandom_range(0, 3);
            repeat (n)
            begin
                raw = $urandom_range(0, 1) ? next_held : held;
                step(raw, $urandom_range(0, cur_ticks / 4));
            end
            step(next_held, $urandom_range(0, cur_ticks / 4));
            held = next_held;
            // quiet scans, usually long enough for the wait to run out
            n = $urandom_range(1, 4);
            repeat (n) step(held, $urandom_range(0, cur_ticks));
        end
    endtask

    initial
    begin
        int quota;
        int pause_at;
        bit paused;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset defaults: eager press, settle at the exact threshold
        scan(64'h0000_0000_0000_0001, 1'b1, 1);
        scan(64'h0000_0000_0000_0001, 1'b0, 2);
        scan(64'h0000_0000_0000_0001, 1'b0, 3);
        // eager press in the top row with another key held
        scan(64'h8000_0000_0000_0001, 1'b1, 1);
        scan(64'h8000_0000_0000_0001, 1'b0, 5);
        // release blocks the eager path, change shows up after the wait
        scan(64'h8000_0000_0000_0000, 1'b1, 1);
        scan(64'h8000_0000_0000_0000, 1'b0, 5);
        // two presses in one row, then single presses in two rows
        scan(64'h8000_0000_0000_0003, 1'b1, 1);
        scan(64'h8000_0000_0000_0003, 1'b0, 5);
        scan(64'h8000_0000_0001_0103, 1'b1, 1);
        scan(64'h8000_0000_0001_0103, 1'b0, 5);
        // all keys down, then all up
        scan(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1);
        scan(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 5);
        scan(64'h0000_0000_0000_0000, 1'b1, 1);
        scan(64'h0000_0000_0000_0000, 1'b0, 5);
        // flag raised with no real change still starts the wait
        scan(64'h0000_0000_0000_0000, 1'b1, 1);
        scan(64'h0000_0000_0000_0000, 1'b0, 5);
        // timestamp wrap across zero
        stim_time = 16'hFFFD;
        scan(64'h0000_0000_0000_0020, 1'b1, 1);
        scan(64'h0000_0000_0000_0020, 1'b0, 4);
        scan(64'h0000_0000_0000_0020, 1'b0, 1);
        // second change while the wait is pending is not eager
        scan(64'h0000_0000_0000_0060, 1'b1, 1);
        scan(64'h0000_0000_0000_00E0, 1'b1, 1);
        scan(64'h0000_0000_0000_00E0, 1'b0, 5);

        // lone-key mode with the shortest wait
        drain();
        load_settings(8'd1, 1'b1);
        scan(64'h0000_0000_0000_00E1, 1'b1, 1);
        scan(64'h0000_0000_0000_00E1, 1'b0, 1);
        scan(64'h0000_0000_0000_0000, 1'b1, 0);
        scan(64'h0000_0000_0000_0000, 1'b0, 0);
        scan(64'h0000_0000_0000_0000, 1'b0, 1);
        scan(64'h0000_0100_0000_0000, 1'b1, 1);
        held = last_raw;

        // random phases over a spread of settings
        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            case (p)
                0: load_settings(8'd1, 1'b0);
                1: load_settings(8'd255, 1'b1);
                2: load_settings(8'd255, 1'b0);
                3: load_settings(8'd1, 1'b1);
                default: load_settings(8'($urandom_range(1, 255)), 1'($urandom_range(0, 1)));
            endcase
            tx_idle_on = 1'($urandom_range(0, 1));
            rx_idle_on <= 1'($urandom_range(0, 1));
            quota    = scans_sent + RANDOM_SCANS / PHASES;
            pause_at = scans_sent + $urandom_range(20, RANDOM_SCANS / PHASES - 20);
            paused   = 1'b0;
            while (scans_sent < quota)
            begin
                // hold off once per phase until everything is back
                if (!paused && scans_sent >= pause_at)
                begin
                    drain();
                    paused     = 1'b1;
                    tx_idle_on = 1'($urandom_range(0, 1));
                    rx_idle_on <= 1'($urandom_range(0, 1));
                end
                random_activity();
            end
        end

        drain();
        repeat (4) @(posedge clk);
        if (words_left != 0)
            $display("%0t: %0d expected words never arrived", $time, words_left);
        $display("%0d scans, %0d results under %0d register settings",
                 scans_sent, results_seen, settings_run);
        $display("(1 to 255 ticks, lone-key on/off) with %0d eager presses, %0d settled changes",
                 eager_count, settle_count);
        $display("%0d mismatches", fail_count);
        if (fail_count == 0 && words_left == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
